### design/sphpc_pkg.sv
package sphpc_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int WORD_W = 32;
   localparam int ACC_W = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = 2;
   localparam logic [31:0] REST_DENSITY_RESET = 32'd65536000;

   // register indexes
   localparam logic [0:0] REG_REST_DENSITY = 1'd0;

   // word passed from front to back
   typedef struct packed {
      logic [31:0] own_density;
      logic        present;
      logic        is_solid;
      logic        last;
      logic [31:0] mass;
      logic [31:0] grad_x;
      logic [31:0] grad_y;
   } item_type;

endpackage

### design/sphpc_front.sv
module sphpc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [31:0]          own_density,
   input  logic                 neighbor_present,
   input  logic                 is_solid,
   input  logic [31:0]          neighbor_volume,
   input  logic [31:0]          grad_x,
   input  logic [31:0]          grad_y,
   input  logic                 last,
   input  logic [31:0]          rest_density,
   output logic                 out_valid,
   output sphpc_pkg::item_type  out_item
);

   logic                out_valid_ff;
   sphpc_pkg::item_type item_ff;
   logic [63:0]         prod;
   logic [63:0]         mass_full;

   always_comb begin
      prod = {32'd0, neighbor_volume} * {32'd0, rest_density};
      mass_full = prod >> sphpc_pkg::FRACTION_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
      item_ff.own_density <= own_density;
      item_ff.present <= neighbor_present;
      item_ff.is_solid <= is_solid;
      item_ff.last <= last;
      item_ff.mass <= (mass_full[63:32] != 32'd0) ? 32'hFFFF_FFFF : mass_full[31:0];
      item_ff.grad_x <= grad_x;
      item_ff.grad_y <= grad_y;
   end

   assign out_valid = out_valid_ff;
   assign out_item = item_ff;

endmodule

### design/sphpc_queue.sv
module sphpc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sphpc_pkg::item_type  push_item,
   input  logic                 pop,
   output logic                 empty,
   output logic [2:0]           count,
   output sphpc_pkg::item_type  head
);

   sphpc_pkg::item_type mem_ff [sphpc_pkg::QUEUE_DEPTH];
   logic [sphpc_pkg::QUEUE_AW-1:0] wr_ff, rd_ff;
   logic [2:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + {2'd0, push} - {2'd0, pop};
      end
      if (push) mem_ff[wr_ff] <= push_item;
   end

   assign empty = (count_ff == 3'd0);
   assign count = count_ff;
   assign head = mem_ff[rd_ff];

endmodule

### design/sphpc_back.sv
module sphpc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  sphpc_pkg::item_type  q_head,
   output logic                 q_pop,
   output logic                 res_valid,
   output logic [31:0]          res_value,
   input  logic                 res_taken
);

   typedef enum logic [2:0] {
      S_MUL, S_ACC, S_DEN0, S_DEN1, S_DIV, S_HOLD
   } state_type;

   state_type   state_ff;
   sphpc_pkg::item_type it_ff;
   logic signed [63:0] px_ff, py_ff;
   logic signed [63:0] sx_ff, sy_ff;
   logic [63:0] sq_ff;
   logic [63:0] qx_ff, qy_ff;
   logic [63:0] den_ff;
   logic [63:0] num_ff, quo_ff;
   logic [63:0] rem_ff;
   logic [6:0]  bit_ff;
   logic        sat_ff;
   logic        res_valid_ff;
   logic [31:0] res_ff;

   logic signed [63:0] tx, ty, fx, fy;
   logic [31:0] ax, ay;
   logic [63:0] bx, by;
   logic [63:0] sqt;
   logic [64:0] sqs, den_sum, rem_shift, rem_diff;
   logic [63:0] nx_sat, ny_sat;
   logic [64:0] sq_new;

   function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [63:0] sadd(input logic signed [63:0] a,
                                        input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      return s[63:0];
   endfunction

   always_comb begin
      // arithmetic shift is floor division by 2^F
      fx = px_ff >>> sphpc_pkg::FRACTION_BITS;
      fy = py_ff >>> sphpc_pkg::FRACTION_BITS;
      tx = sat32(fx);
      ty = sat32(fy);
      nx_sat = sadd(sx_ff, tx);
      ny_sat = sadd(sy_ff, ty);
      // terms are in the signed 32-bit range, so magnitudes fit 32 bits
      ax = tx[63] ? 32'(-tx) : 32'(tx);
      ay = ty[63] ? 32'(-ty) : 32'(ty);
      sqt = {32'd0, ax} * {32'd0, ax} + {32'd0, ay} * {32'd0, ay};
      sq_new = {1'b0, sq_ff} + {1'b0, sqt >> sphpc_pkg::FRACTION_BITS};
      bx = sx_ff[63] ? -sx_ff : sx_ff;
      by = sy_ff[63] ? -sy_ff : sy_ff;
      sqs = {1'b0, qx_ff} + {1'b0, qy_ff};
      den_sum = {1'b0, sqs[63:0] >> sphpc_pkg::FRACTION_BITS} + {1'b0, sq_ff};
      rem_shift = {rem_ff, num_ff[63]};
      rem_diff = rem_shift - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_MUL;
         res_valid_ff <= 1'b0;
         sx_ff <= '0;
         sy_ff <= '0;
         sq_ff <= '0;
         it_ff.present <= 1'b0;
         it_ff.last <= 1'b0;
      end else begin
         if (res_valid_ff && res_taken) res_valid_ff <= 1'b0;
         unique case (state_ff)
            S_MUL: if (!q_empty) begin
               it_ff <= q_head;
               px_ff <= $signed({32'd0, q_head.mass}) *
                        $signed({{32{q_head.grad_x[31]}}, q_head.grad_x});
               py_ff <= $signed({32'd0, q_head.mass}) *
                        $signed({{32{q_head.grad_y[31]}}, q_head.grad_y});
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (it_ff.present) begin
                  sx_ff <= nx_sat;
                  sy_ff <= ny_sat;
                  if (!it_ff.is_solid)
                     sq_ff <= sq_new[64] ? '1 : sq_new[63:0];
               end
               state_ff <= it_ff.last ? S_DEN0 : S_MUL;
            end
            S_DEN0: begin
               sat_ff <= (bx[63:32] != 32'd0) || (by[63:32] != 32'd0);
               qx_ff <= {32'd0, bx[31:0]} * {32'd0, bx[31:0]};
               qy_ff <= {32'd0, by[31:0]} * {32'd0, by[31:0]};
               state_ff <= S_DEN1;
            end
            S_DEN1: begin
               if (sat_ff || sqs[64] || sqs[63:0] == '1 || den_sum[64])
                  den_ff <= '1;
               else
                  den_ff <= den_sum[63:0];
               num_ff <= {32'd0, it_ff.own_density} * {32'd0, it_ff.own_density};
               rem_ff <= '0;
               quo_ff <= '0;
               bit_ff <= 7'd0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // restoring division, one quotient bit a cycle
               if (rem_shift >= {1'b0, den_ff}) begin
                  rem_ff <= rem_diff[63:0];
                  quo_ff <= {quo_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= rem_shift[63:0];
                  quo_ff <= {quo_ff[62:0], 1'b0};
               end
               num_ff <= {num_ff[62:0], 1'b0};
               bit_ff <= bit_ff + 7'd1;
               if (bit_ff == 7'd63) state_ff <= S_HOLD;
            end
            S_HOLD: if (!res_valid_ff) begin
               if (den_ff == '0) res_ff <= '0;
               else res_ff <= (quo_ff[63:32] != 32'd0) ? 32'hFFFF_FFFF : quo_ff[31:0];
               res_valid_ff <= 1'b1;
               sx_ff <= '0;
               sy_ff <= '0;
               sq_ff <= '0;
               state_ff <= S_MUL;
            end
            default: state_ff <= S_MUL;
         endcase
      end
   end

   assign q_pop = (state_ff == S_MUL) && !q_empty;
   assign res_valid = res_valid_ff;
   assign res_value = res_ff;

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && bit_ff == 7'd63 |=> state_ff == S_HOLD)
      else $error("divider ran past 64 steps");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == S_MUL)
      else $error("queue popped while busy");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      $rose(res_valid_ff) |-> sq_ff == '0 && sx_ff == '0)
      else $error("sums not cleared after result");
endmodule

### design/sph_pressure_coefficient.sv
// One word per neighbor: the front stage registers the mass product and feeds a
// four-entry queue; the back end multiplies and then accumulates each word, and
// a last word then passes two denominator states and the 64-step restoring
// divider. Results sit in a one-word output register while the next words queue.
module sph_pressure_coefficient (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_own_density,
   input  logic        req_neighbor_present,
   input  logic        req_is_solid,
   input  logic [31:0] req_neighbor_volume,
   input  logic [31:0] req_grad_x,
   input  logic [31:0] req_grad_y,
   input  logic        req_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_coefficient,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [31:0] rest_density_ff;
   logic        f_valid, q_empty, q_pop, res_valid, accept;
   logic [2:0]  q_count;
   sphpc_pkg::item_type f_item, q_head;

   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) rest_density_ff <= sphpc_pkg::REST_DENSITY_RESET;
      else if (psel && penable && pwrite &&
               paddr == 2'(4 * sphpc_pkg::REG_REST_DENSITY))
         rest_density_ff <= pwdata;
   end
   assign prdata = (paddr == 2'(4 * sphpc_pkg::REG_REST_DENSITY)) ? rest_density_ff : 32'd0;

   // leave room for the word still in the front register
   assign req_full = reset ||
                     ((q_count + {2'd0, f_valid}) >= 3'(sphpc_pkg::QUEUE_DEPTH - 1));
   assign accept = req_push && !req_full;

   sphpc_front u_front (
      .clock, .reset, .in_valid(accept),
      .own_density(req_own_density), .neighbor_present(req_neighbor_present),
      .is_solid(req_is_solid), .neighbor_volume(req_neighbor_volume),
      .grad_x(req_grad_x), .grad_y(req_grad_y), .last(req_last),
      .rest_density(rest_density_ff), .out_valid(f_valid), .out_item(f_item)
   );

   sphpc_queue u_queue (
      .clock, .reset, .push(f_valid), .push_item(f_item), .pop(q_pop),
      .empty(q_empty), .count(q_count), .head(q_head)
   );

   sphpc_back u_back (
      .clock, .reset, .q_empty, .q_head, .q_pop,
      .res_valid, .res_value(rsp_coefficient), .res_taken(rsp_pop)
   );

   assign rsp_empty = !res_valid;

endmodule
